FILE: hw/rtl/rcbp_pkg.sv
// shared types, opcodes and helpers of the register command byte parser
package rcbp_pkg;

    // default register file size in bytes
    localparam int unsigned REG_BYTES_DEF = 128;

    // command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // opcodes of the host command stream
    localparam logic [7:0] OP_NOP   = 8'h00;
    localparam logic [7:0] OP_ECHO  = 8'h0d;
    localparam logic [7:0] OP_RD1   = 8'h10;
    localparam logic [7:0] OP_RD2   = 8'h11;
    localparam logic [7:0] OP_RD4   = 8'h12;
    localparam logic [7:0] OP_FRD_A = 8'h13;
    localparam logic [7:0] OP_FRD_B = 8'h18;
    localparam logic [7:0] OP_WR1   = 8'h20;
    localparam logic [7:0] OP_WR2   = 8'h21;
    localparam logic [7:0] OP_WR4   = 8'h22;
    localparam logic [7:0] OP_WR8   = 8'h23;
    localparam logic [7:0] OP_FWR   = 8'h28;

    // reply to the echo opcode, ascii '2'
    localparam logic [7:0] ECHO_CHAR = 8'h32;

    typedef enum logic [1:0] {
        EV_REPLY      = 2'd0,
        EV_WRITE_DONE = 2'd1,
        EV_FIFO_RD    = 2'd2,
        EV_FIFO_WR    = 2'd3
    } ev_kind_t;

    typedef enum logic [1:0] {
        CMD_EVENT = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_kind_t;

    // work item handed from front to back
    typedef struct packed {
        cmd_kind_t  cmd;
        ev_kind_t   kind;
        logic [7:0] addr;   // event address
        logic [7:0] idx;    // register file index
        logic [7:0] data;
        logic       emit;   // write also reports write done
        logic [2:0] cnt;    // read length in bytes
    } cmd_t;

    // one result item
    typedef struct packed {
        ev_kind_t   kind;
        logic [7:0] addr;
        logic [7:0] data;
        logic       last;
    } ev_t;

    // byte address modulo register file size by reciprocal multiplication,
    // recip is ceil(2^16 / n), exact for every byte address
    function automatic logic [7:0] reg_mod(input logic [7:0] a, input int unsigned n,
                                           input int unsigned recip);
        logic [24:0] prod;
        logic [7:0]  quo;
        logic [16:0] qn;
        logic [16:0] rem;
        prod = 25'(a) * recip[24:0];
        quo  = prod[23:16];
        qn   = 17'(quo) * n[16:0];
        rem  = 17'(a) - qn;
        return rem[7:0];
    endfunction

endpackage

FILE: hw/rtl/rcbp_front.sv
// command parser front: accepts stream bytes and turns them into queued work items
module rcbp_front #(
    parameter int unsigned REG_BYTES = rcbp_pkg::REG_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_rx_byte,
    input  logic             q_full,
    output logic             q_push,
    output rcbp_pkg::cmd_t   q_cmd
);

    // reciprocal of the register file size for the index reduction
    localparam int unsigned IDX_RECIP = (32'd65536 + REG_BYTES - 1) / REG_BYTES;

    typedef enum logic [1:0] {
        PH_OPCODE,
        PH_ADDR,
        PH_ARG
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] opcode_reg, opcode_next;
    logic [7:0] cur_reg, cur_next;
    logic [7:0] start_reg, start_next;
    logic [7:0] end_reg, end_next;
    logic [7:0] fifo_left_reg, fifo_left_next;

    logic       acc;
    logic [7:0] cur_inc;
    logic [7:0] idx_byte;
    logic [7:0] idx_cur;

    assign s_ready  = !q_full;
    assign acc      = s_valid && s_ready;
    assign cur_inc  = cur_reg + 8'd1;
    assign idx_byte = rcbp_pkg::reg_mod(s_rx_byte, REG_BYTES, IDX_RECIP);
    assign idx_cur  = rcbp_pkg::reg_mod(cur_reg, REG_BYTES, IDX_RECIP);

    // parse one byte
    always_comb begin
        phase_next     = phase_reg;
        opcode_next    = opcode_reg;
        cur_next       = cur_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        fifo_left_next = fifo_left_reg;
        q_push         = 1'b0;
        q_cmd.cmd      = rcbp_pkg::CMD_EVENT;
        q_cmd.kind     = rcbp_pkg::EV_REPLY;
        q_cmd.addr     = cur_reg;
        q_cmd.idx      = idx_cur;
        q_cmd.data     = s_rx_byte;
        q_cmd.emit     = 1'b0;
        q_cmd.cnt      = 3'd1;
        if (acc) begin
            if (fifo_left_reg != 8'd0) begin
                // fifo pass-through, parser suspended
                q_push         = 1'b1;
                q_cmd.kind     = rcbp_pkg::EV_FIFO_WR;
                fifo_left_next = fifo_left_reg - 8'd1;
            end else begin
                case (phase_reg)
                    PH_OPCODE: begin
                        opcode_next = s_rx_byte;
                        if (s_rx_byte == rcbp_pkg::OP_ECHO) begin
                            q_push     = 1'b1;
                            q_cmd.addr = 8'd0;
                            q_cmd.data = rcbp_pkg::ECHO_CHAR;
                        end else if (s_rx_byte != rcbp_pkg::OP_NOP) begin
                            phase_next = PH_ADDR;
                        end
                    end
                    PH_ADDR: begin
                        start_next = s_rx_byte;
                        cur_next   = s_rx_byte;
                        case (opcode_reg)
                            rcbp_pkg::OP_WR2: end_next = s_rx_byte + 8'd2;
                            rcbp_pkg::OP_WR4: end_next = s_rx_byte + 8'd4;
                            rcbp_pkg::OP_WR8: end_next = s_rx_byte + 8'd8;
                            default: end_next = end_reg;
                        endcase
                        if (opcode_reg inside {rcbp_pkg::OP_RD1, rcbp_pkg::OP_RD2,
                                               rcbp_pkg::OP_RD4}) begin
                            q_push     = 1'b1;
                            q_cmd.cmd  = rcbp_pkg::CMD_READ;
                            q_cmd.idx  = idx_byte;
                            q_cmd.cnt  = (opcode_reg == rcbp_pkg::OP_RD1) ? 3'd1 :
                                         (opcode_reg == rcbp_pkg::OP_RD2) ? 3'd2 : 3'd4;
                            phase_next = PH_OPCODE;
                        end else begin
                            phase_next = PH_ARG;
                        end
                    end
                    PH_ARG: begin
                        phase_next = PH_OPCODE;
                        case (opcode_reg)
                            rcbp_pkg::OP_FRD_A, rcbp_pkg::OP_FRD_B: begin
                                q_push     = 1'b1;
                                q_cmd.kind = rcbp_pkg::EV_FIFO_RD;
                            end
                            rcbp_pkg::OP_WR1: begin
                                q_push     = 1'b1;
                                q_cmd.cmd  = rcbp_pkg::CMD_WRITE;
                                q_cmd.emit = 1'b1;
                            end
                            rcbp_pkg::OP_WR2, rcbp_pkg::OP_WR4, rcbp_pkg::OP_WR8: begin
                                q_push     = 1'b1;
                                q_cmd.cmd  = rcbp_pkg::CMD_WRITE;
                                q_cmd.addr = start_reg;
                                q_cmd.emit = (cur_inc == end_reg);
                                cur_next   = cur_inc;
                                if (cur_inc != end_reg) begin
                                    phase_next = PH_ARG;
                                end
                            end
                            rcbp_pkg::OP_FWR: begin
                                fifo_left_next = s_rx_byte;
                            end
                            default: begin
                                // unknown opcode, byte swallowed
                                phase_next = PH_OPCODE;
                            end
                        endcase
                    end
                    default: phase_next = PH_OPCODE;
                endcase
            end
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_OPCODE;
            opcode_reg    <= 8'd0;
            cur_reg       <= 8'd0;
            start_reg     <= 8'd0;
            end_reg       <= 8'd0;
            fifo_left_reg <= 8'd0;
        end else begin
            phase_reg     <= phase_next;
            opcode_reg    <= opcode_next;
            cur_reg       <= cur_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            fifo_left_reg <= fifo_left_next;
        end
    end

endmodule

FILE: hw/rtl/rcbp_queue.sv
// short work item queue between parser front and executing back
module rcbp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_push,
    input  rcbp_pkg::cmd_t q_cmd,
    input  logic           q_pop,
    output rcbp_pkg::cmd_t q_head,
    output logic           q_full,
    output logic           q_empty
);

    localparam int unsigned PTR_W = $clog2(rcbp_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(rcbp_pkg::QUEUE_DEPTH + 1);

    rcbp_pkg::cmd_t   store_reg [rcbp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == CNT_W'(rcbp_pkg::QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign q_head  = store_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (q_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(rcbp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + PTR_W'(1);
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(rcbp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + PTR_W'(1);
        end
        if (q_push && !q_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (!q_push && q_pop) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (q_push) begin
            store_reg[wr_ptr_reg] <= q_cmd;
        end
    end

endmodule

FILE: hw/rtl/rcbp_back.sv
// executing back: register file, read bursts and result output register
module rcbp_back #(
    parameter int unsigned REG_BYTES = rcbp_pkg::REG_BYTES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  rcbp_pkg::cmd_t q_head,
    input  logic           q_empty,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_event_kind,
    output logic [7:0]     m_event_address,
    output logic [7:0]     m_event_data,
    output logic           m_last_of_run
);

    localparam int unsigned IDX_W = $clog2(REG_BYTES);

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
        return (v == IDX_W'(REG_BYTES - 1)) ? '0 : v + IDX_W'(1);
    endfunction

    // read burst state
    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [2:0]       left_reg, left_next;

    // issue stage and output register
    logic          p1_valid_reg, p1_valid_next;
    rcbp_pkg::ev_t p1_ev_reg, p1_ev_next;
    logic          p1_mem_reg, p1_mem_next;
    logic          m_valid_reg, m_valid_next;
    rcbp_pkg::ev_t m_ev_reg;

    // register file with per-byte valid bits
    logic [7:0]       mem [REG_BYTES];
    logic [REG_BYTES-1:0] vld_reg;
    logic [7:0]       mem_q_reg;
    logic             rdv_q_reg;

    logic             p1_adv;
    logic             issue_en;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] head_idx;
    logic [7:0]       out_data;

    assign head_idx = q_head.idx[IDX_W-1:0];
    assign p1_adv   = p1_valid_reg && (!m_valid_reg || m_ready);
    assign issue_en = !p1_valid_reg || p1_adv;

    // issue one work step per cycle while the issue stage is free or advancing
    always_comb begin
        busy_next     = busy_reg;
        rd_idx_next   = rd_idx_reg;
        left_next     = left_reg;
        p1_valid_next = p1_adv ? 1'b0 : p1_valid_reg;
        p1_ev_next    = p1_ev_reg;
        p1_mem_next   = p1_mem_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        rd_idx        = rd_idx_reg;
        wr_en         = 1'b0;
        if (issue_en) begin
            if (busy_reg) begin
                // continue a read burst
                rd_en           = 1'b1;
                p1_valid_next   = 1'b1;
                p1_mem_next     = 1'b1;
                p1_ev_next.kind = rcbp_pkg::EV_REPLY;
                p1_ev_next.addr = 8'(rd_idx_reg);
                p1_ev_next.data = 8'd0;
                p1_ev_next.last = (left_reg == 3'd1);
                rd_idx_next     = wrap_inc(rd_idx_reg);
                left_next       = left_reg - 3'd1;
                busy_next       = (left_reg != 3'd1);
            end else if (!q_empty) begin
                q_pop = 1'b1;
                case (q_head.cmd)
                    rcbp_pkg::CMD_EVENT: begin
                        p1_valid_next   = 1'b1;
                        p1_mem_next     = 1'b0;
                        p1_ev_next.kind = q_head.kind;
                        p1_ev_next.addr = q_head.addr;
                        p1_ev_next.data = q_head.data;
                        p1_ev_next.last = 1'b1;
                    end
                    rcbp_pkg::CMD_WRITE: begin
                        wr_en = 1'b1;
                        if (q_head.emit) begin
                            p1_valid_next   = 1'b1;
                            p1_mem_next     = 1'b0;
                            p1_ev_next.kind = rcbp_pkg::EV_WRITE_DONE;
                            p1_ev_next.addr = q_head.addr;
                            p1_ev_next.data = 8'd0;
                            p1_ev_next.last = 1'b1;
                        end
                    end
                    rcbp_pkg::CMD_READ: begin
                        rd_en           = 1'b1;
                        rd_idx          = head_idx;
                        p1_valid_next   = 1'b1;
                        p1_mem_next     = 1'b1;
                        p1_ev_next.kind = rcbp_pkg::EV_REPLY;
                        p1_ev_next.addr = 8'(head_idx);
                        p1_ev_next.data = 8'd0;
                        p1_ev_next.last = (q_head.cnt == 3'd1);
                        rd_idx_next     = wrap_inc(head_idx);
                        left_next       = q_head.cnt - 3'd1;
                        busy_next       = (q_head.cnt != 3'd1);
                    end
                    default: begin
                        p1_valid_next = p1_valid_next;
                    end
                endcase
            end
        end
    end

    // output register takes the issue stage when free or drained
    assign m_valid_next = p1_adv ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    assign out_data     = p1_mem_reg ? (rdv_q_reg ? mem_q_reg : 8'd0) : p1_ev_reg.data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            vld_reg      <= '0;
        end else begin
            busy_reg     <= busy_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (wr_en) begin
                vld_reg[head_idx] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        left_reg   <= left_next;
        p1_ev_reg  <= p1_ev_next;
        p1_mem_reg <= p1_mem_next;
        if (p1_adv) begin
            m_ev_reg.kind <= p1_ev_reg.kind;
            m_ev_reg.addr <= p1_ev_reg.addr;
            m_ev_reg.data <= out_data;
            m_ev_reg.last <= p1_ev_reg.last;
        end
    end

    // register file write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[head_idx] <= q_head.data;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_idx];
            rdv_q_reg <= vld_reg[rd_idx];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_kind    = m_ev_reg.kind;
    assign m_event_address = m_ev_reg.addr;
    assign m_event_data    = m_ev_reg.data;
    assign m_last_of_run   = m_ev_reg.last;

endmodule

FILE: hw/rtl/register_command_byte_parser_core.sv
// register command byte parser: host command stream in, reply and fifo events out
//
// s_ channel carries one command byte per transfer (s_rx_byte); m_ channel carries
// one event per transfer: kind, address, data and a flag on the last event of a read burst and on every other event.
// The front parses a byte per cycle and pushes work items into a four-entry queue;
// s_ready drops only while that queue is full.
// The back runs one work step per cycle, while the issue stage can advance, through the
// register file's single port: a read command of 1, 2 or 4 bytes takes one step per byte, everything else one.
// An accepted byte passes the queue, the issue stage and the output register to m_valid.
// Sustained rate is one event per cycle while m_ready holds; a byte stream of 4-byte reads
// is bound by the port, which gives four results for each opcode and address byte pair.
// Reset clears the parser, the queue, the pipeline and all register file bytes
// (per-byte valid bits, no clearing pass), and the block is ready the cycle after.
// When the receiver stalls, the output register holds its event; the back stalls,
// then the queue fills and s_ready falls, with no event lost or repeated.
module register_command_byte_parser_core #(
    parameter int unsigned REG_BYTES = rcbp_pkg::REG_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_event_kind,
    output logic [7:0] m_event_address,
    output logic [7:0] m_event_data,
    output logic       m_last_of_run
);

    rcbp_pkg::cmd_t q_cmd;
    rcbp_pkg::cmd_t q_head;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;

    rcbp_front #(
        .REG_BYTES(REG_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_rx_byte(s_rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    rcbp_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_push (q_push),
        .q_cmd  (q_cmd),
        .q_pop  (q_pop),
        .q_head (q_head),
        .q_full (q_full),
        .q_empty(q_empty)
    );

    rcbp_back #(
        .REG_BYTES(REG_BYTES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_head         (q_head),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_event_address(m_event_address),
        .m_event_data   (m_event_data),
        .m_last_of_run  (m_last_of_run)
    );

    // front never pushes into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue push while full");

    // back only takes an item that is there
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    // reset leaves queue and output empty
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (q_empty && !m_valid))
        else $error("state not cleared by reset");

endmodule
